// ----- rtl/core/mrfs_pkg.sv -----
// Package for the Modbus RTU frame sniffer: sizes, codes, shared types and
// the CRC-16 byte update. No dependencies.
`default_nettype none

package mrfs_pkg;

   localparam int FRAME_DEPTH = 256;
   localparam int AW          = $clog2(FRAME_DEPTH);
   localparam int MEM_AW      = AW + 1;
   localparam int CW          = $clog2(FRAME_DEPTH + 1);
   localparam int LW          = (CW > 9) ? CW : 9;
   localparam int XW          = (CW > 10) ? CW : 10;
   localparam int IW          = (AW > 8) ? AW : 8;
   localparam int CSR_IW      = 3;
   localparam int CSR_DW      = 16;

   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'hA001;
   localparam logic [7:0]  EXC_BIT   = 8'h80;
   localparam logic [7:0]  COUNT_MAX = 8'd250;

   localparam logic [7:0] FC_READ_HOLD   = 8'd3;
   localparam logic [7:0] FC_READ_INPUT  = 8'd4;
   localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
   localparam logic [7:0] FC_WRITE_REG   = 8'd6;
   localparam logic [7:0] FC_WRITE_COILS = 8'd15;
   localparam logic [7:0] FC_WRITE_REGS  = 8'd16;

   localparam logic [1:0] OP_BYTE = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [1:0] ST_NONE     = 2'd0;
   localparam logic [1:0] ST_CAPTURED = 2'd1;
   localparam logic [1:0] ST_BAD      = 2'd2;
   localparam logic [1:0] ST_ADDRESS  = 2'd3;

   localparam logic [CSR_IW-1:0] CSR_ADDR_FILTER = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_KEEP_CRC    = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_FIX_EN      = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_FIXED_LEN   = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_TIMEOUT     = 3'd4;

   typedef struct packed {
      logic [7:0]  address_filter;
      logic        keep_crc;
      logic        fix_length_enable;
      logic [8:0]  fixed_length;
      logic [15:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic              we;
      logic [MEM_AW-1:0] waddr;
      logic [7:0]        wdata;
      logic              re;
      logic [MEM_AW-1:0] raddr;
   } mem_req_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) c = (c >> 1) ^ CRC_POLY;
         else      c = c >> 1;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mrfs_chan_if.sv -----
// Valid/ready channel interfaces for the sniffer's request and response sides.
// No dependencies.
`default_nettype none

interface mrfs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] rx_byte;
   logic [7:0] read_index;

   modport source (output valid, op, rx_byte, read_index, input ready);
   modport sink   (input valid, op, rx_byte, read_index, output ready);
endinterface

interface mrfs_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] frame_status;
   logic       ended_by_timeout;
   logic       is_request;
   logic [8:0] captured_length;
   logic [7:0] read_data;

   modport source (output valid, frame_status, ended_by_timeout, is_request,
                   captured_length, read_data, input ready);
   modport sink   (input valid, frame_status, ended_by_timeout, is_request,
                   captured_length, read_data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/mrfs_frame_buf.sv -----
// Two-bank frame byte store: one write port, one registered read port.
// Depends on mrfs_pkg.
`default_nettype none

module mrfs_frame_buf (
   input  wire logic                 clock,
   input  wire mrfs_pkg::mem_req_type mem_req,
   output logic [7:0]                mem_q
);
   import mrfs_pkg::*;

   logic [7:0] store_ff [2**MEM_AW];
   logic [7:0] q_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         store_ff[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         q_ff <= store_ff[mem_req.raddr];
      end
   end

   assign mem_q = q_ff;

endmodule

`default_nettype wire

// ----- rtl/core/mrfs_frame_ctl.sv -----
// Frame tracking: input register, CRC / length-rule / capture logic, result
// register. Depends on mrfs_pkg, mrfs_chan_if and mrfs_frame_buf.
`default_nettype none

module mrfs_frame_ctl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire mrfs_pkg::cfg_type cfg,
   mrfs_req_if.sink              req_if,
   mrfs_rsp_if.source            rsp_if
);
   import mrfs_pkg::*;

   // input stage
   logic       in_valid_ff, in_valid_in;
   logic [1:0] op_ff;
   logic [7:0] byte_ff;
   logic [7:0] idx_ff;

   // frame state
   logic          bank_ff, bank_in;
   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    fc_ff, fc_in;
   logic [7:0]    third_ff, third_in;
   logic [7:0]    seventh_ff, seventh_in;
   logic [7:0]    addr0_ff, addr0_in;
   logic [15:0]   idle_ff, idle_in;
   logic [CW-1:0] cap_stored_ff, cap_stored_in;
   logic [LW-1:0] cap_final_ff, cap_final_in;
   logic          cap_req_ff, cap_req_in;

   // frame state after the current byte or tick, before any frame end
   logic [CW-1:0] count_rx;
   logic [15:0]   crc_rx;
   logic [15:0]   idle_rx;

   // result stage
   logic       out_valid_ff, out_valid_in;
   logic [1:0] status_ff, status_in;
   logic       tmo_ff, tmo_in;
   logic       isreq_ff;
   logic [8:0] len_ff, len_in;
   logic       hit_ff, hit_in;

   logic          advance;
   logic          do_end;
   logic          rule_met;
   logic          third_ok;
   logic          fc_rd;
   logic [XW-1:0] n_x;
   logic [XW-1:0] third_lim;
   logic [XW-1:0] seventh_lim;
   logic [CW-1:0] stored;
   logic [LW-1:0] lim;
   logic [IW-1:0] idx_w;
   logic [7:0]    mem_q;
   mem_req_type   mem_req;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign in_valid_in  = req_if.valid ? 1'b1 : (in_valid_ff && !advance);
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_if.ready);

   // byte, tick and read handling
   always_comb begin
      count_rx      = count_ff;
      crc_rx        = crc_ff;
      fc_in         = fc_ff;
      third_in      = third_ff;
      seventh_in    = seventh_ff;
      addr0_in      = addr0_ff;
      idle_rx       = idle_ff;
      tmo_in        = 1'b0;
      hit_in        = 1'b0;
      idx_w         = IW'(idx_ff);
      lim           = (LW'(cap_stored_ff) < cap_final_ff) ? LW'(cap_stored_ff) : cap_final_ff;
      mem_req.we    = 1'b0;
      mem_req.waddr = {bank_ff, count_ff[AW-1:0]};
      mem_req.wdata = byte_ff;
      mem_req.re    = 1'b0;
      mem_req.raddr = {~bank_ff, idx_w[AW-1:0]};

      case (op_ff)
         OP_BYTE: begin
            if (count_ff < CW'(FRAME_DEPTH)) begin
               mem_req.we = advance;
               count_rx   = count_ff + CW'(1);
               crc_rx     = crc_byte(crc_ff, byte_ff);
               if (count_ff == CW'(0)) addr0_in   = byte_ff;
               if (count_rx == CW'(2)) fc_in      = byte_ff;
               if (count_rx == CW'(3)) third_in   = byte_ff;
               if (count_rx == CW'(7)) seventh_in = byte_ff;
            end
            idle_rx = 16'd0;
         end
         OP_TICK: begin
            if (count_ff != CW'(0)) begin
               if (idle_ff >= cfg.timeout_ticks) begin
                  tmo_in = 1'b1;
               end else begin
                  idle_rx = idle_ff + 16'd1;
               end
            end
         end
         OP_READ: begin
            hit_in     = (LW'(idx_ff) < lim) && (LW'(idx_ff) < LW'(FRAME_DEPTH));
            mem_req.re = advance && hit_in;
         end
         default: begin
         end
      endcase
   end

   // length rule on the post-byte frame state
   always_comb begin
      n_x         = XW'(count_rx);
      third_lim   = XW'(third_in) + XW'(5);
      seventh_lim = XW'(seventh_in) + XW'(9);
      third_ok    = third_in >= 8'd1 && third_in <= COUNT_MAX;
      fc_rd       = fc_in == FC_READ_HOLD || fc_in == FC_READ_INPUT;
      stored      = cfg.keep_crc ? count_rx : count_rx - CW'(2);
      rule_met    = 1'b0;
      if (n_x >= XW'(4) && crc_rx == 16'd0) begin
         if ((fc_in & EXC_BIT) != 8'd0) begin
            rule_met = n_x >= XW'(5);
         end else begin
            case (fc_in)
               FC_READ_HOLD, FC_READ_INPUT:
                  rule_met = n_x >= XW'(8) || (third_ok && n_x >= third_lim);
               FC_WRITE_COIL, FC_WRITE_REG:
                  rule_met = n_x >= XW'(8);
               FC_WRITE_COILS, FC_WRITE_REGS:
                  rule_met = n_x >= XW'(7) && n_x >= seventh_lim;
               default:
                  rule_met = 1'b0;
            endcase
         end
      end
   end

   // frame end: discard or capture, then restart the receive state
   always_comb begin
      bank_in       = bank_ff;
      count_in      = count_rx;
      crc_in        = crc_rx;
      idle_in       = idle_rx;
      cap_stored_in = cap_stored_ff;
      cap_final_in  = cap_final_ff;
      cap_req_in    = cap_req_ff;
      status_in     = ST_NONE;
      do_end        = tmo_in || (op_ff == OP_BYTE && rule_met);

      if (do_end) begin
         if (count_rx < CW'(4) || crc_rx != 16'd0) begin
            status_in = ST_BAD;
         end else if (cfg.address_filter != 8'd0 && addr0_in != cfg.address_filter) begin
            status_in = ST_ADDRESS;
         end else begin
            status_in     = ST_CAPTURED;
            cap_stored_in = stored;
            cap_final_in  = cfg.fix_length_enable ? LW'(cfg.fixed_length) : LW'(stored);
            cap_req_in    = !(fc_rd && n_x != XW'(8) && third_ok && n_x == third_lim);
            bank_in       = ~bank_ff;
         end
         count_in = '0;
         crc_in   = CRC_INIT;
         idle_in  = 16'd0;
      end

      len_in = (cap_final_in > LW'(511)) ? 9'd511 : cap_final_in[8:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         bank_ff       <= 1'b0;
         count_ff      <= '0;
         crc_ff        <= CRC_INIT;
         fc_ff         <= 8'd0;
         third_ff      <= 8'd0;
         seventh_ff    <= 8'd0;
         idle_ff       <= 16'd0;
         cap_stored_ff <= '0;
         cap_final_ff  <= '0;
         cap_req_ff    <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            bank_ff       <= bank_in;
            count_ff      <= count_in;
            crc_ff        <= crc_in;
            fc_ff         <= fc_in;
            third_ff      <= third_in;
            seventh_ff    <= seventh_in;
            idle_ff       <= idle_in;
            cap_stored_ff <= cap_stored_in;
            cap_final_ff  <= cap_final_in;
            cap_req_ff    <= cap_req_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready) begin
         op_ff   <= req_if.op;
         byte_ff <= req_if.rx_byte;
         idx_ff  <= req_if.read_index;
      end
      if (advance) begin
         addr0_ff  <= addr0_in;
         status_ff <= status_in;
         tmo_ff    <= tmo_in;
         isreq_ff  <= cap_req_in;
         len_ff    <= len_in;
         hit_ff    <= hit_in;
      end
   end

   mrfs_frame_buf u_buf (
      .clock   (clock),
      .mem_req (mem_req),
      .mem_q   (mem_q)
   );

   assign rsp_if.valid            = out_valid_ff;
   assign rsp_if.frame_status     = status_ff;
   assign rsp_if.ended_by_timeout = tmo_ff;
   assign rsp_if.is_request       = isreq_ff;
   assign rsp_if.captured_length  = len_ff;
   assign rsp_if.read_data        = hit_ff ? mem_q : 8'd0;

endmodule

`default_nettype wire

// ----- rtl/core/modbus_rtu_frame_sniffer.sv -----
// Top level of the Modbus RTU frame sniffer: control registers and the frame
// tracking core. Depends on mrfs_pkg, mrfs_chan_if and mrfs_frame_ctl.
//
// Every request (received byte, idle tick, or read of a captured byte) gives
// exactly one response. One request is taken per clock unless the response
// side stalls; its response passes through the input register, then the
// result register with the frame store's registered read port beside it. A
// waiting response still lets one more request into the input register; after
// that the request side stalls until the response transfers. The frame store
// is two banks of 256 bytes in one memory; it needs no clearing after reset,
// since only bytes of a finished capture are ever read back. Write the control
// registers only while no request is in flight.
`default_nettype none

module modbus_rtu_frame_sniffer (
   input  wire logic                         clock,
   input  wire logic                         reset,
   mrfs_req_if.sink                          req_if,
   mrfs_rsp_if.source                        rsp_if,
   input  wire logic                         csr_we,
   input  wire logic [mrfs_pkg::CSR_IW-1:0]  csr_index,
   input  wire logic [mrfs_pkg::CSR_DW-1:0]  csr_wdata
);
   import mrfs_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.address_filter    <= 8'd0;
         cfg_ff.keep_crc          <= 1'b0;
         cfg_ff.fix_length_enable <= 1'b0;
         cfg_ff.fixed_length      <= 9'd0;
         cfg_ff.timeout_ticks     <= 16'd50;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ADDR_FILTER: cfg_ff.address_filter    <= csr_wdata[7:0];
            CSR_KEEP_CRC:    cfg_ff.keep_crc          <= csr_wdata[0];
            CSR_FIX_EN:      cfg_ff.fix_length_enable <= csr_wdata[0];
            CSR_FIXED_LEN:   cfg_ff.fixed_length      <= csr_wdata[8:0];
            CSR_TIMEOUT:     cfg_ff.timeout_ticks     <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   mrfs_frame_ctl u_ctl (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule

`default_nettype wire

// ----- rtl/core/mrfs_checker.sv -----
// Port-level assertions for the sniffer top, with the bind that attaches them.
// Depends on mrfs_pkg and modbus_rtu_frame_sniffer.
`default_nettype none

module mrfs_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_frame_status,
   input wire logic       rsp_ended_by_timeout,
   input wire logic       rsp_is_request,
   input wire logic [8:0] rsp_captured_length,
   input wire logic [7:0] rsp_read_data
);
   import mrfs_pkg::*;

   a_rst_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_status)
         && $stable(rsp_captured_length) && $stable(rsp_read_data))
      else $error("stalled response changed");

   a_tmo_has_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ended_by_timeout |-> rsp_frame_status != ST_NONE)
      else $error("timeout flag without frame end");

   a_read_no_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_data != 8'd0 |-> rsp_frame_status == ST_NONE
         && !rsp_ended_by_timeout)
      else $error("read data on a frame end response");

   a_discard_keeps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && !rsp_is_request |=> !rsp_is_request)
      else $error("frame class changed under stall");

endmodule

bind modbus_rtu_frame_sniffer mrfs_checker u_mrfs_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_if.valid),
   .rsp_ready            (rsp_if.ready),
   .rsp_frame_status     (rsp_if.frame_status),
   .rsp_ended_by_timeout (rsp_if.ended_by_timeout),
   .rsp_is_request       (rsp_if.is_request),
   .rsp_captured_length  (rsp_if.captured_length),
   .rsp_read_data        (rsp_if.read_data)
);

`default_nettype wire
